@@ hw/rtl/rhts_pkg.sv @@
// Shared constants, codes and types of the railcar holding-track sorter.
`default_nettype none
package rhts_pkg;

    localparam int TRACKS        = 16;
    localparam int TRACK_DEPTH   = 64;

    localparam int TRACK_W       = $clog2(TRACKS);
    localparam int DEPTH_W       = $clog2(TRACK_DEPTH);
    localparam int FILL_W        = $clog2(TRACK_DEPTH + 1);
    localparam int ADDR_W        = TRACK_W + DEPTH_W;
    localparam int RAM_DEPTH     = TRACKS * (2 ** DEPTH_W);

    localparam int CMD_W         = 2;
    localparam int CAR_W         = 10;
    localparam int TOTAL_W       = 11;
    localparam int STATUS_W      = 3;
    localparam int TRACK_FIELD_W = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_DRAIN = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STS_PLACED    = 3'd0,
        STS_RELEASED  = 3'd1,
        STS_NO_ROOM   = 3'd2,
        STS_NOT_FOUND = 3'd3,
        STS_ALL_DONE  = 3'd4,
        STS_CLEARED   = 3'd5
    } t_status;

    typedef struct packed {
        t_status                  status;
        logic [TRACK_FIELD_W-1:0] track;
        logic [CAR_W-1:0]         car;
    } t_result;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [CAR_W-1:0]  data;
    } t_ram_wr;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_ram_rd;

endpackage
`default_nettype wire

@@ hw/rtl/rhts_track_ram.sv @@
// Car storage: one circular buffer per track, one write and one read port.
`default_nettype none
module rhts_track_ram (
    input  wire logic                    i_clk,
    input  wire rhts_pkg::t_ram_wr       i_wr,
    input  wire rhts_pkg::t_ram_rd       i_rd,
    output logic [rhts_pkg::CAR_W-1:0]   o_rdata
);

    logic [rhts_pkg::CAR_W-1:0] r_mem [rhts_pkg::RAM_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            o_rdata <= r_mem[i_rd.addr];
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/rhts_ctrl.sv @@
// Track bookkeeping: tail/head compare, pointer update and head refill.
`default_nettype none
module rhts_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_req,
    input  wire rhts_pkg::t_cmd                i_cmd,
    input  wire logic [rhts_pkg::CAR_W-1:0]    i_car,
    input  wire logic [rhts_pkg::TOTAL_W-1:0]  i_car_total,
    output logic                               o_busy,
    output logic                               o_res_valid,
    output rhts_pkg::t_result                  o_res,
    output rhts_pkg::t_ram_wr                  o_ram_wr,
    output rhts_pkg::t_ram_rd                  o_ram_rd,
    input  wire logic [rhts_pkg::CAR_W-1:0]    i_ram_rdata
);

    localparam int SUM_W = rhts_pkg::FILL_W + 1;

    typedef enum logic {
        S_IDLE,
        S_REFILL
    } t_state;

    t_state                            r_state, n_state;
    logic [rhts_pkg::DEPTH_W-1:0]      r_head_ptr [rhts_pkg::TRACKS];
    logic [rhts_pkg::FILL_W-1:0]       r_fill     [rhts_pkg::TRACKS];
    logic [rhts_pkg::CAR_W-1:0]        r_tail     [rhts_pkg::TRACKS];
    logic [rhts_pkg::CAR_W-1:0]        r_head_val [rhts_pkg::TRACKS];
    logic [rhts_pkg::TOTAL_W-1:0]      r_next_exp;
    logic [rhts_pkg::TRACK_W-1:0]      r_refill_trk;

    logic [rhts_pkg::TRACKS-1:0]       ld_qual, dr_hit;
    logic                              ld_found, dr_found, dr_done;
    logic [rhts_pkg::TRACK_W-1:0]      ld_idx, dr_idx;
    logic [SUM_W-1:0]                  slot_sum;
    logic [rhts_pkg::DEPTH_W-1:0]      ld_slot, dr_next_head;
    logic                              do_load, do_pop, do_clear, do_refill;

    // per-track qualification, all tracks in parallel
    always_comb begin
        for (int t = 0; t < rhts_pkg::TRACKS; t++) begin
            ld_qual[t] = (r_fill[t] < rhts_pkg::FILL_W'(rhts_pkg::TRACK_DEPTH)) &&
                         ((r_fill[t] == '0) || (r_tail[t] < i_car));
            dr_hit[t]  = (r_fill[t] != '0) &&
                         ({1'b0, r_head_val[t]} == r_next_exp);
        end
    end

    // lowest-numbered track wins
    always_comb begin
        ld_found = 1'b0;
        ld_idx   = '0;
        dr_found = 1'b0;
        dr_idx   = '0;
        for (int t = rhts_pkg::TRACKS - 1; t >= 0; t--) begin
            if (ld_qual[t]) begin
                ld_found = 1'b1;
                ld_idx   = rhts_pkg::TRACK_W'(t);
            end
            if (dr_hit[t]) begin
                dr_found = 1'b1;
                dr_idx   = rhts_pkg::TRACK_W'(t);
            end
        end
    end

    // append slot = (head + fill) mod depth; sum stays below twice the depth
    always_comb begin
        slot_sum = SUM_W'(r_head_ptr[ld_idx]) + SUM_W'(r_fill[ld_idx]);
        if (slot_sum >= SUM_W'(rhts_pkg::TRACK_DEPTH)) begin
            ld_slot = rhts_pkg::DEPTH_W'(slot_sum - SUM_W'(rhts_pkg::TRACK_DEPTH));
        end else begin
            ld_slot = rhts_pkg::DEPTH_W'(slot_sum);
        end
        if (SUM_W'(r_head_ptr[dr_idx]) + SUM_W'(1) == SUM_W'(rhts_pkg::TRACK_DEPTH)) begin
            dr_next_head = '0;
        end else begin
            dr_next_head = r_head_ptr[dr_idx] + rhts_pkg::DEPTH_W'(1);
        end
    end

    assign dr_done   = r_next_exp > i_car_total;
    assign do_load   = i_req && (i_cmd == rhts_pkg::CMD_LOAD) && ld_found;
    assign do_pop    = i_req && (i_cmd == rhts_pkg::CMD_DRAIN) && !dr_done && dr_found;
    assign do_clear  = i_req && (i_cmd == rhts_pkg::CMD_CLEAR);
    // the new head only comes from memory when a car remains behind the popped one
    assign do_refill = do_pop && (r_fill[dr_idx] > rhts_pkg::FILL_W'(1));

    // result
    always_comb begin
        o_res_valid = i_req && (i_cmd != rhts_pkg::CMD_NONE);
        o_res       = '{status: rhts_pkg::STS_CLEARED, track: '0, car: '0};
        case (i_cmd)
            rhts_pkg::CMD_LOAD: begin
                if (ld_found) begin
                    o_res = '{status: rhts_pkg::STS_PLACED,
                              track:  rhts_pkg::TRACK_FIELD_W'(ld_idx),
                              car:    i_car};
                end else begin
                    o_res.status = rhts_pkg::STS_NO_ROOM;
                end
            end
            rhts_pkg::CMD_DRAIN: begin
                if (dr_done) begin
                    o_res.status = rhts_pkg::STS_ALL_DONE;
                end else if (dr_found) begin
                    o_res = '{status: rhts_pkg::STS_RELEASED,
                              track:  rhts_pkg::TRACK_FIELD_W'(dr_idx),
                              car:    r_head_val[dr_idx]};
                end else begin
                    o_res.status = rhts_pkg::STS_NOT_FOUND;
                end
            end
            default: begin
                o_res.status = rhts_pkg::STS_CLEARED;
            end
        endcase
    end

    assign o_ram_wr = '{en: do_load, addr: {ld_idx, ld_slot}, data: i_car};
    assign o_ram_rd = '{en: do_refill, addr: {dr_idx, dr_next_head}};
    assign o_busy   = (r_state == S_REFILL);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   n_state = do_refill ? S_REFILL : S_IDLE;
            S_REFILL: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_next_exp <= rhts_pkg::TOTAL_W'(1);
            for (int t = 0; t < rhts_pkg::TRACKS; t++) begin
                r_head_ptr[t] <= '0;
                r_fill[t]     <= '0;
                r_tail[t]     <= '0;
            end
        end else begin
            r_state <= n_state;
            if (do_clear) begin
                r_next_exp <= rhts_pkg::TOTAL_W'(1);
                for (int t = 0; t < rhts_pkg::TRACKS; t++) begin
                    r_head_ptr[t] <= '0;
                    r_fill[t]     <= '0;
                    r_tail[t]     <= '0;
                end
            end
            if (do_load) begin
                r_fill[ld_idx] <= r_fill[ld_idx] + rhts_pkg::FILL_W'(1);
                r_tail[ld_idx] <= i_car;
            end
            if (do_pop) begin
                r_head_ptr[dr_idx] <= dr_next_head;
                r_fill[dr_idx]     <= r_fill[dr_idx] - rhts_pkg::FILL_W'(1);
                r_next_exp         <= r_next_exp + rhts_pkg::TOTAL_W'(1);
            end
        end
    end

    // head value cache: written on first car, refilled from memory after a pop
    always_ff @(posedge i_clk) begin
        if (do_load && (r_fill[ld_idx] == '0)) begin
            r_head_val[ld_idx] <= i_car;
        end
        if (do_refill) begin
            r_refill_trk <= dr_idx;
        end
        if (r_state == S_REFILL) begin
            r_head_val[r_refill_trk] <= i_ram_rdata;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/railcar_holding_track_sorter_unit.sv @@
// Top level of the railcar holding-track sorter: stream ports, config and result register.
// The result of an accepted request is registered and shows on the master side in the cycle after acceptance.
// Throughput: one request per cycle while the master takes results; a drain that releases
//   a car with more cars behind it stalls the slave side while the new head is read from the track RAM.
// Reset (synchronous, active low): all tracks empty, next expected car 1, car total 0,
//   result register empty. Track RAM contents are not cleared; only written slots are read.
`default_nettype none
module railcar_holding_track_sorter_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side: requests
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [1:0] cmd, [11:2] car, rest zero
    // master side: results
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [2:0] status, [6:3] track, [16:7] car_out
    // car_total register
    input  wire logic        i_cfg_we,
    input  wire logic [10:0] i_cfg_wdata
);

    logic [rhts_pkg::TOTAL_W-1:0] r_car_total;
    logic                         r_out_valid;
    rhts_pkg::t_result            r_out;

    logic                         req_acc;
    logic                         ctrl_busy;
    logic                         res_valid;
    rhts_pkg::t_result            res;
    rhts_pkg::t_ram_wr            ram_wr;
    rhts_pkg::t_ram_rd            ram_rd;
    logic [rhts_pkg::CAR_W-1:0]   ram_rdata;
    rhts_pkg::t_cmd               req_cmd;
    logic [rhts_pkg::CAR_W-1:0]   req_car;

    assign req_cmd = rhts_pkg::t_cmd'(s_axis_tdata[1:0]);
    assign req_car = s_axis_tdata[11:2];

    // take a request only when the head refill is done and the result slot
    // is empty or drains this cycle
    assign s_axis_tready = !ctrl_busy && (!r_out_valid || m_axis_tready);
    assign req_acc       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_car_total <= '0;
        end else if (i_cfg_we) begin
            r_car_total <= i_cfg_wdata;
        end
    end

    rhts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_acc),
        .i_cmd       (req_cmd),
        .i_car       (req_car),
        .i_car_total (r_car_total),
        .o_busy      (ctrl_busy),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_ram_wr    (ram_wr),
        .o_ram_rd    (ram_rd),
        .i_ram_rdata (ram_rdata)
    );

    rhts_track_ram u_ram (
        .i_clk   (i_clk),
        .i_wr    (ram_wr),
        .i_rd    (ram_rd),
        .o_rdata (ram_rdata)
    );

    // result register; the unused command produces nothing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.car, r_out.track, r_out.status};

endmodule
`default_nettype wire

@@ verif/railcar_holding_track_sorter_unit_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the railcar holding-track sorter with random stream traffic.
module railcar_holding_track_sorter_unit_test;

    // Scoreboard: keeps its own copy of the yard (tracks, heads, fills, tails,
    // next car due out) and queues the outcome of every accepted request that yields a result.
    class yard_scoreboard;
        logic [rhts_pkg::CAR_W-1:0]   slot_car   [rhts_pkg::TRACKS][rhts_pkg::TRACK_DEPTH];
        logic [rhts_pkg::DEPTH_W-1:0] head_slot  [rhts_pkg::TRACKS];
        logic [rhts_pkg::FILL_W-1:0]  fill_count [rhts_pkg::TRACKS];
        logic [rhts_pkg::CAR_W-1:0]   last_car   [rhts_pkg::TRACKS];
        logic [rhts_pkg::TOTAL_W-1:0] next_car;
        logic [rhts_pkg::TOTAL_W-1:0] car_total;
        rhts_pkg::t_result            outcome_q[$];
        int                           mismatches;
        int                           status_hits [6];

        function new();
            empty_yard();
            car_total  = '0;
            mismatches = 0;
            foreach (status_hits[i]) status_hits[i] = 0;
        endfunction

        function void empty_yard();
            foreach (head_slot[t]) begin
                head_slot[t]  = '0;
                fill_count[t] = '0;
                last_car[t]   = '0;
            end
            next_car = rhts_pkg::TOTAL_W'(1);
        endfunction

        function void set_total(logic [rhts_pkg::TOTAL_W-1:0] value);
            car_total = value;
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction

        // Work out the outcome of one accepted request and queue it if it yields a result.
        function void note_request(rhts_pkg::t_cmd cmd, logic [rhts_pkg::CAR_W-1:0] car);
            rhts_pkg::t_result            r;
            bit                           done;
            logic [rhts_pkg::DEPTH_W-1:0] slot;
            r.status = rhts_pkg::STS_NO_ROOM;
            r.track  = '0;
            r.car    = '0;
            done     = 1'b0;
            case (cmd)
                rhts_pkg::CMD_LOAD: begin
                    // first track with room that is empty or ends below this car
                    for (int t = 0; t < rhts_pkg::TRACKS && !done; t++) begin
                        if (fill_count[t] < rhts_pkg::TRACK_DEPTH &&
                            (fill_count[t] == 0 || last_car[t] < car)) begin
                            slot = head_slot[t] + fill_count[t][rhts_pkg::DEPTH_W-1:0];
                            slot_car[t][slot] = car;
                            fill_count[t]     = fill_count[t] + 1'b1;
                            last_car[t]       = car;
                            r.status = rhts_pkg::STS_PLACED;
                            r.track  = rhts_pkg::TRACK_FIELD_W'(t);
                            r.car    = car;
                            done     = 1'b1;
                        end
                    end
                    outcome_q.push_back(r);
                end
                rhts_pkg::CMD_DRAIN: begin
                    if (next_car > car_total) begin
                        r.status = rhts_pkg::STS_ALL_DONE;
                    end else begin
                        r.status = rhts_pkg::STS_NOT_FOUND;
                        for (int t = 0; t < rhts_pkg::TRACKS && !done; t++) begin
                            if (fill_count[t] != 0 &&
                                slot_car[t][head_slot[t]] == next_car) begin
                                r.status = rhts_pkg::STS_RELEASED;
                                r.track  = rhts_pkg::TRACK_FIELD_W'(t);
                                r.car    = slot_car[t][head_slot[t]];
                                head_slot[t]  = head_slot[t] + 1'b1;
                                fill_count[t] = fill_count[t] - 1'b1;
                                next_car      = next_car + 1'b1;
                                done          = 1'b1;
                            end
                        end
                    end
                    outcome_q.push_back(r);
                end
                rhts_pkg::CMD_CLEAR: begin
                    empty_yard();
                    r.status = rhts_pkg::STS_CLEARED;
                    outcome_q.push_back(r);
                end
                default: ;  // unused code: no result
            endcase
        endfunction

        // Compare one accepted result against the oldest queued outcome.
        function void check_result(logic [23:0] data);
            rhts_pkg::t_result want;
            if (outcome_q.size() == 0) begin
                $error("result with no request pending: tdata %h", data);
                mismatches++;
                return;
            end
            want = outcome_q.pop_front();
            status_hits[int'(want.status)]++;
            if (data[2:0] !== want.status) begin
                $error("status mismatch: expected %0d, actual %0d", want.status, data[2:0]);
                mismatches++;
            end
            if (data[6:3] !== want.track) begin
                $error("track mismatch: expected %0d, actual %0d", want.track, data[6:3]);
                mismatches++;
            end
            if (data[16:7] !== want.car) begin
                $error("car_out mismatch: expected %0d, actual %0d", want.car, data[16:7]);
                mismatches++;
            end
        endfunction
    endclass

    // Clock, reset and every DUT input start at known values.
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;    // [1:0] cmd, [11:2] car, rest zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // [2:0] status, [6:3] track, [16:7] car_out
    logic        i_cfg_we      = 1'b0;
    logic [10:0] i_cfg_wdata   = '0;

    yard_scoreboard yard = new();

    int src_idle_pct  = 8;     // percent chance per cycle that the sender holds off
    int dst_idle_pct  = 74;    // percent chance per cycle that the receiver stalls
    int requests_sent = 0;     // accepted requests that produce a result
    int noise_count   = 0;

    always #5 i_clk = ~i_clk;

    railcar_holding_track_sorter_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // Receiver: random back-pressure, updated on the falling edge.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // Result monitor: sample the handshake on the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            yard.check_result(m_axis_tdata);
        end
    end

    // Drive one request. tvalid stays high after acceptance so back-to-back
    // requests need not drop it; a hold-off in the next call or the drain pause lowers it.
    task automatic send_request(input rhts_pkg::t_cmd cmd,
                                input logic [rhts_pkg::CAR_W-1:0] car);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, car, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        yard.note_request(cmd, car);
        if (cmd != rhts_pkg::CMD_NONE) requests_sent++;
    endtask

    // Hold the sender off until every queued outcome has been checked, then
    // let the block finish any head refill.
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (yard.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // car_total write; only called with the block idle.
    task automatic write_total(input logic [rhts_pkg::TOTAL_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        yard.set_total(value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic send_drain();
        send_request(rhts_pkg::CMD_DRAIN, rhts_pkg::CAR_W'($urandom_range(1023)));
    endtask

    // Well-formed batch: a shuffled run 1..n loaded with drains mixed in,
    // then drained out to completion. A broken batch corrupts one car.
    task automatic run_sorted_batch(input bit broken);
        int cars[$];
        int n;
        int j;
        int tmp;
        int drains;
        n = $urandom_range(1, 60);
        for (int c = 1; c <= n; c++) cars.push_back(c);
        for (int i = n - 1; i > 0; i--) begin
            j       = $urandom_range(i);
            tmp     = cars[i];
            cars[i] = cars[j];
            cars[j] = tmp;
        end
        if (broken) cars[$urandom_range(n - 1)] = $urandom_range(1023);
        wait_drained();
        write_total(($urandom_range(3) == 0) ? rhts_pkg::TOTAL_W'(n + $urandom_range(5))
                                             : rhts_pkg::TOTAL_W'(n));
        drains = 0;
        foreach (cars[i]) begin
            send_request(rhts_pkg::CMD_LOAD, rhts_pkg::CAR_W'(cars[i]));
            if ($urandom_range(99) < 35) begin
                send_drain();
                drains++;
            end
            if ($urandom_range(49) == 0) begin
                send_request(rhts_pkg::CMD_NONE, rhts_pkg::CAR_W'($urandom_range(1023)));
            end
        end
        while (drains < n + 2) begin
            send_drain();
            drains++;
        end
        send_request(rhts_pkg::CMD_CLEAR, rhts_pkg::CAR_W'($urandom_range(1023)));
    endtask

    // Ascending loads overflow track 0 into track 1; the second round
    // reuses track 0 after its head pointer has wrapped.
    task automatic run_fill_batch();
        wait_drained();
        write_total(rhts_pkg::TOTAL_W'(132));
        for (int c = 1; c <= 66; c++) send_request(rhts_pkg::CMD_LOAD, rhts_pkg::CAR_W'(c));
        wait_drained();    // sender parked until every result is back
        repeat (66) send_drain();
        for (int c = 67; c <= 132; c++) send_request(rhts_pkg::CMD_LOAD, rhts_pkg::CAR_W'(c));
        repeat (68) send_drain();
        send_request(rhts_pkg::CMD_CLEAR, rhts_pkg::CAR_W'($urandom_range(1023)));
    endtask

    // Noise: any command, car numbers small or anywhere in range.
    task automatic run_noise_batch();
        int                         k;
        rhts_pkg::t_cmd             cmd;
        logic [rhts_pkg::CAR_W-1:0] car;
        wait_drained();
        case (noise_count % 4)
            0:       write_total(rhts_pkg::TOTAL_W'(1024));
            1:       write_total(rhts_pkg::TOTAL_W'(1023));
            2:       write_total(rhts_pkg::TOTAL_W'(0));
            default: write_total(rhts_pkg::TOTAL_W'($urandom_range(1, 40)));
        endcase
        noise_count++;
        repeat ($urandom_range(15, 40)) begin
            k = $urandom_range(19);
            if (k < 9)       cmd = rhts_pkg::CMD_LOAD;
            else if (k < 17) cmd = rhts_pkg::CMD_DRAIN;
            else if (k < 18) cmd = rhts_pkg::CMD_CLEAR;
            else             cmd = rhts_pkg::CMD_NONE;
            car = $urandom_range(1) ? rhts_pkg::CAR_W'($urandom_range(1, 24))
                                    : rhts_pkg::CAR_W'($urandom_range(1023));
            send_request(cmd, car);
        end
        send_request(rhts_pkg::CMD_CLEAR, rhts_pkg::CAR_W'($urandom_range(1023)));
    endtask

    // Directed opening: completion with total 0, not-found, placement order,
    // the ignored code, releases in order, clear, and a yard with no room.
    task automatic run_directed();
        send_drain();                            // total 0 after reset: all released
        wait_drained();
        write_total(rhts_pkg::TOTAL_W'(3));
        send_drain();                            // car 1 nowhere yet
        send_request(rhts_pkg::CMD_LOAD, rhts_pkg::CAR_W'(3));
        send_request(rhts_pkg::CMD_LOAD, rhts_pkg::CAR_W'(1));
        send_request(rhts_pkg::CMD_LOAD, rhts_pkg::CAR_W'(2));
        send_request(rhts_pkg::CMD_NONE, rhts_pkg::CAR_W'(1023));    // ignored
        repeat (4) send_drain();                 // 1, 2, 3, then complete
        send_request(rhts_pkg::CMD_CLEAR, rhts_pkg::CAR_W'(1023));
        repeat (16) send_request(rhts_pkg::CMD_LOAD, rhts_pkg::CAR_W'(1023));
        send_request(rhts_pkg::CMD_LOAD, rhts_pkg::CAR_W'(0));       // every tail too high
        send_request(rhts_pkg::CMD_CLEAR, rhts_pkg::CAR_W'(0));
    endtask

    initial begin
        int  phase_end;
        int  pick;
        bit  fill_done;
        fill_done = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        // Three pressure phases: sender mostly busy with a slow receiver,
        // then the reverse, then full rate on both sides.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin src_idle_pct = 8;  dst_idle_pct = 74; end
                1:       begin src_idle_pct = 74; dst_idle_pct = 8;  end
                default: begin src_idle_pct = 0;  dst_idle_pct = 0;  end
            endcase
            phase_end = requests_sent + 333;
            while (requests_sent < phase_end) begin
                pick = $urandom_range(19);
                if (!fill_done || pick == 0) begin
                    run_fill_batch();
                    fill_done = 1'b1;
                end else if (pick < 5) begin
                    run_noise_batch();
                end else if (pick < 7) begin
                    run_sorted_batch(1'b1);
                end else begin
                    run_sorted_batch(1'b0);
                end
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("Ran %0d requests through three back-pressure phases, car_total 0 to 1024.",
                 requests_sent);
        $display("Outcomes: placed %0d, released %0d, no room %0d, not found %0d,",
                 yard.status_hits[0], yard.status_hits[1], yard.status_hits[2],
                 yard.status_hits[3]);
        $display("          done %0d, cleared %0d",
                 yard.status_hits[4], yard.status_hits[5]);
        if (yard.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #(5_000_000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ railcar_holding_track_sorter_unit.f @@
hw/rtl/rhts_pkg.sv
hw/rtl/rhts_track_ram.sv
hw/rtl/rhts_ctrl.sv
hw/rtl/railcar_holding_track_sorter_unit.sv
verif/railcar_holding_track_sorter_unit_test.sv
